FILE: sv/rtpaac_pkg.sv
// ---------------------------------------------------------------------------
// rtpaac_pkg
// Shared types and constants for the RTP AAC access-unit depacketizer.
// ---------------------------------------------------------------------------
package rtpaac_pkg;

  localparam int BYTE_W         = 8;
  localparam int LEN_W          = 16;   // AU-headers-length field
  localparam int SIZE_W         = 16;   // stored AU size
  localparam int ACC_W          = 24;   // header field accumulator
  localparam int FCNT_W         = 5;    // bits gathered in current header
  localparam int SIZE_BITS_W    = 5;
  localparam int INDEX_BITS_W   = 4;
  localparam int AU_NUM_W       = 6;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 5;

  localparam logic [SIZE_BITS_W-1:0]  MAX_SIZE_BITS  = 5'd16;
  localparam logic [INDEX_BITS_W-1:0] MAX_INDEX_BITS = 4'd8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_BITS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS = 2'd1;

  // status of the header-length remainder unit
  typedef struct packed {
    logic busy;
    logic rem_zero;
  } chk_status_t;

endpackage

FILE: sv/rtpaac_len_check.sv
// ---------------------------------------------------------------------------
// rtpaac_len_check
// Bit-serial remainder of the header length by the header width, one
// dividend bit per cycle (restoring form).
// ---------------------------------------------------------------------------
module rtpaac_len_check
  import rtpaac_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [LEN_W-1:0]       dividend,
  input  logic [SIZE_BITS_W-1:0] divisor,
  output chk_status_t            st
);

  localparam int CNT_W = $clog2(LEN_W + 1);

  logic [LEN_W-1:0]       dvd_r, dvd_nxt;
  logic [SIZE_BITS_W-1:0] div_r, div_nxt;
  logic [SIZE_BITS_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;
  logic [SIZE_BITS_W:0]   trial;

  assign trial = {rem_r, dvd_r[LEN_W-1]};

  always_comb begin
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      dvd_nxt  = dividend;
      div_nxt  = divisor;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(LEN_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // remainder stays below the divisor, so the difference fits
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = SIZE_BITS_W'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = trial[SIZE_BITS_W-1:0];
      end
      dvd_nxt = {dvd_r[LEN_W-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign st.busy     = busy_r;
  assign st.rem_zero = (rem_r == '0);

endmodule

FILE: sv/rtpaac_unit_table.sv
// ---------------------------------------------------------------------------
// rtpaac_unit_table
// AU size table: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module rtpaac_unit_table
  import rtpaac_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [SIZE_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [SIZE_W-1:0] rdata
);

  logic [SIZE_W-1:0] mem [DEPTH];
  logic [SIZE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/rtp_aac_au_depacketizer.sv
// ---------------------------------------------------------------------------
// rtp_aac_au_depacketizer
// Parses the AU-header section of an RTP AAC payload and streams the
// access-unit bytes tagged with AU number and end-of-AU mark.
// ---------------------------------------------------------------------------
// Flow: length and discarded bytes are taken as they arrive, data bytes while
//   the output is free; a header byte is accepted, then walked one header bit
//   at a time (bit-serial walk). After the second length byte come a 16-step
//   remainder and a decision (skipped on a zero length or width), plus output
//   wait. Each access unit adds fetch and load states; results are registered.
// Reset: synchronous rst_n clears all control state; the size table is not.
module rtp_aac_au_depacketizer
  import rtpaac_pkg::*;
#(
  parameter int MAX_UNITS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input items
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [BYTE_W-1:0]     in_payload_byte,
  input  logic                  in_packet_start,
  input  logic                  in_packet_end,
  // result items
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [BYTE_W-1:0]     out_au_byte,
  output logic [AU_NUM_W-1:0]   out_au_number,
  output logic                  out_au_last,
  output logic                  out_header_error,
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
  localparam int CNT_W = $clog2(MAX_UNITS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_UNITS);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LEN_LO,
    ST_CHECK,
    ST_HEADER,
    ST_HBITS,
    ST_FETCH,
    ST_LOAD,
    ST_DATA,
    ST_DISCARD
  } phase_t;

  phase_t                  phase_r, phase_nxt;
  logic [LEN_W-1:0]        len_r, len_nxt;
  logic [LEN_W:0]          consumed_r, consumed_nxt;
  logic [ACC_W-1:0]        acc_r, acc_nxt;
  logic [FCNT_W-1:0]       fcnt_r, fcnt_nxt;
  logic [CNT_W-1:0]        ucount_r, ucount_nxt;
  logic [CNT_W-1:0]        ridx_r, ridx_nxt;
  logic [SIZE_W-1:0]       left_r, left_nxt;
  logic                    closed_r, closed_nxt;
  logic [SIZE_BITS_W-1:0]  size_cfg_r, size_cfg_nxt;
  logic [INDEX_BITS_W-1:0] idx_cfg_r, idx_cfg_nxt;
  logic [INDEX_BITS_W-1:0] lat_idx_r, lat_idx_nxt;
  logic [SIZE_BITS_W-1:0]  width_r, width_nxt;
  logic                    zero_err_r, zero_err_nxt;
  logic                    end_pend_r, end_pend_nxt;
  logic [BYTE_W-1:0]       hbyte_r, hbyte_nxt;
  logic [2:0]              bit_r, bit_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]       out_byte_r, out_byte_nxt;
  logic [AU_NUM_W-1:0]     out_num_r, out_num_nxt;
  logic                    out_last_r, out_last_nxt;
  logic                    out_err_r, out_err_nxt;

  logic                    in_acc;
  logic                    out_free;
  logic                    out_load;
  logic                    chk_start;
  chk_status_t             chk_st;
  logic                    tbl_we;
  logic [SIZE_W-1:0]       tbl_rdata;

  logic [SIZE_BITS_W-1:0]  lat_size_c;
  logic [INDEX_BITS_W-1:0] lat_idx_c;
  logic [SIZE_BITS_W-1:0]  width_c;
  logic [LEN_W-1:0]        len_full_c;
  logic                    hb_bit;
  logic [ACC_W-1:0]        acc_sh;
  logic [FCNT_W-1:0]       fcnt_inc;
  logic [SIZE_W-1:0]       sz_val;
  logic [CNT_W+AU_NUM_W-1:0] ridx_ext;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !(phase_r inside {ST_IDLE, ST_LEN_LO, ST_HEADER, ST_DATA, ST_DISCARD})
                     || (phase_r == ST_DATA && !out_free);
  assign in_acc    = in_valid && !in_stall;

  // field widths clamp to 16 and 8
  assign lat_size_c = (size_cfg_r > MAX_SIZE_BITS) ? MAX_SIZE_BITS : size_cfg_r;
  assign lat_idx_c  = (idx_cfg_r > MAX_INDEX_BITS) ? MAX_INDEX_BITS : idx_cfg_r;
  assign width_c    = lat_size_c + SIZE_BITS_W'(lat_idx_c);
  assign len_full_c = {len_r[LEN_W-1:BYTE_W], in_payload_byte};

  assign hb_bit   = hbyte_r[3'd7 - bit_r];
  assign acc_sh   = {acc_r[ACC_W-2:0], hb_bit};
  assign fcnt_inc = fcnt_r + FCNT_W'(1);
  assign sz_val   = SIZE_W'(acc_sh >> lat_idx_r);
  assign ridx_ext = {{AU_NUM_W{1'b0}}, ridx_r};

  rtpaac_len_check u_len_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (chk_start),
    .dividend (len_full_c),
    .divisor  (width_c),
    .st       (chk_st)
  );

  rtpaac_unit_table #(
    .DEPTH (MAX_UNITS),
    .AW    (IDX_W)
  ) u_unit_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (ucount_r[IDX_W-1:0]),
    .wdata (sz_val),
    .raddr (ridx_r[IDX_W-1:0]),
    .rdata (tbl_rdata)
  );

  always_comb begin
    phase_nxt     = phase_r;
    len_nxt       = len_r;
    consumed_nxt  = consumed_r;
    acc_nxt       = acc_r;
    fcnt_nxt      = fcnt_r;
    ucount_nxt    = ucount_r;
    ridx_nxt      = ridx_r;
    left_nxt      = left_r;
    closed_nxt    = closed_r;
    size_cfg_nxt  = size_cfg_r;
    idx_cfg_nxt   = idx_cfg_r;
    lat_idx_nxt   = lat_idx_r;
    width_nxt     = width_r;
    zero_err_nxt  = zero_err_r;
    end_pend_nxt  = end_pend_r;
    hbyte_nxt     = hbyte_r;
    bit_nxt       = bit_r;
    out_byte_nxt  = out_byte_r;
    out_num_nxt   = out_num_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_load      = 1'b0;
    chk_start     = 1'b0;
    tbl_we        = 1'b0;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SIZE_BITS:  size_cfg_nxt = cfg_data;
        REG_INDEX_BITS: idx_cfg_nxt  = cfg_data[INDEX_BITS_W-1:0];
        default: ;
      endcase
    end

    case (phase_r)
      ST_CHECK: begin
        if (zero_err_r || !chk_st.busy) begin
          if (zero_err_r || !chk_st.rem_zero) begin
            if (out_free) begin
              out_load     = 1'b1;
              out_byte_nxt = '0;
              out_num_nxt  = '0;
              out_last_nxt = 1'b0;
              out_err_nxt  = 1'b1;
              phase_nxt    = end_pend_r ? ST_IDLE : ST_DISCARD;
            end
          end else begin
            phase_nxt = end_pend_r ? ST_IDLE : ST_HEADER;
          end
        end
      end
      ST_HBITS: begin
        if (consumed_r < {1'b0, len_r}) begin
          if (fcnt_inc >= width_r) begin
            // a zero size closes the table for the rest of the packet
            if (sz_val == '0) begin
              closed_nxt = 1'b1;
            end else if (!closed_r && ucount_r < MAX_CNT) begin
              tbl_we     = 1'b1;
              ucount_nxt = ucount_r + CNT_W'(1);
            end
            acc_nxt  = '0;
            fcnt_nxt = '0;
          end else begin
            acc_nxt  = acc_sh;
            fcnt_nxt = fcnt_inc;
          end
        end
        consumed_nxt = consumed_r + (LEN_W+1)'(1);
        bit_nxt      = bit_r + 3'd1;
        if (bit_r == 3'd7) begin
          if (consumed_nxt >= {1'b0, len_r}) begin
            ridx_nxt  = '0;
            phase_nxt = (ucount_nxt != '0) ? ST_FETCH : ST_DISCARD;
          end else begin
            phase_nxt = ST_HEADER;
          end
        end
      end
      ST_FETCH: phase_nxt = ST_LOAD;   // table read in flight
      ST_LOAD: begin
        left_nxt  = tbl_rdata;
        phase_nxt = ST_DATA;
      end
      default: ;
    endcase

    if (in_acc) begin
      if (in_packet_start) begin
        len_nxt      = {in_payload_byte, {BYTE_W{1'b0}}};
        consumed_nxt = '0;
        acc_nxt      = '0;
        fcnt_nxt     = '0;
        ucount_nxt   = '0;
        ridx_nxt     = '0;
        left_nxt     = '0;
        closed_nxt   = 1'b0;
        phase_nxt    = ST_LEN_LO;
      end else begin
        case (phase_r)
          ST_LEN_LO: begin
            len_nxt      = len_full_c;
            lat_idx_nxt  = lat_idx_c;
            width_nxt    = width_c;
            zero_err_nxt = (len_full_c == '0) || (width_c == '0);
            chk_start    = !zero_err_nxt;
            end_pend_nxt = in_packet_end;
            phase_nxt    = ST_CHECK;
          end
          ST_HEADER: begin
            hbyte_nxt = in_payload_byte;
            bit_nxt   = '0;
            phase_nxt = ST_HBITS;
          end
          ST_DATA: begin
            out_load     = 1'b1;
            out_byte_nxt = in_payload_byte;
            out_num_nxt  = ridx_ext[AU_NUM_W-1:0];
            out_last_nxt = (left_r == SIZE_W'(1));
            out_err_nxt  = 1'b0;
            left_nxt     = left_r - SIZE_W'(1);
            if (left_r == SIZE_W'(1)) begin
              ridx_nxt  = ridx_r + CNT_W'(1);
              phase_nxt = (ridx_r + CNT_W'(1) < ucount_r) ? ST_FETCH : ST_DISCARD;
            end
          end
          default: ;
        endcase
      end
      // the second length byte still owes its check; its end is held
      if (in_packet_end && (in_packet_start || phase_r != ST_LEN_LO)) begin
        phase_nxt = ST_IDLE;
      end
    end

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= ST_IDLE;
      len_r       <= '0;
      consumed_r  <= '0;
      acc_r       <= '0;
      fcnt_r      <= '0;
      ucount_r    <= '0;
      ridx_r      <= '0;
      left_r      <= '0;
      closed_r    <= 1'b0;
      size_cfg_r  <= SIZE_BITS_W'(13);
      idx_cfg_r   <= INDEX_BITS_W'(3);
      lat_idx_r   <= '0;
      width_r     <= '0;
      zero_err_r  <= 1'b0;
      end_pend_r  <= 1'b0;
      bit_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      len_r       <= len_nxt;
      consumed_r  <= consumed_nxt;
      acc_r       <= acc_nxt;
      fcnt_r      <= fcnt_nxt;
      ucount_r    <= ucount_nxt;
      ridx_r      <= ridx_nxt;
      left_r      <= left_nxt;
      closed_r    <= closed_nxt;
      size_cfg_r  <= size_cfg_nxt;
      idx_cfg_r   <= idx_cfg_nxt;
      lat_idx_r   <= lat_idx_nxt;
      width_r     <= width_nxt;
      zero_err_r  <= zero_err_nxt;
      end_pend_r  <= end_pend_nxt;
      bit_r       <= bit_nxt;
      out_valid_r <= out_valid_nxt;
    end
    hbyte_r    <= hbyte_nxt;
    out_byte_r <= out_byte_nxt;
    out_num_r  <= out_num_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_au_byte      = out_byte_r;
  assign out_au_number    = out_num_r;
  assign out_au_last      = out_last_r;
  assign out_header_error = out_err_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ucount_r <= MAX_CNT)
    else $error("unit count above table depth");

  a_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_we |-> (phase_r == ST_HBITS && !closed_r))
    else $error("table written outside header walk");

  a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == ST_DATA) |-> (left_r != '0))
    else $error("data phase with no bytes left in unit");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !chk_st.busy)
    else $error("item accepted while length check runs");

  a_err_from_check: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_err_nxt) |=> (out_valid_r && out_header_error
      && $past(phase_r) == ST_CHECK))
    else $error("header error result not from length check");
`endif

endmodule
